// File: sv/plen_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plen_pkg: shared types and constants of the positional list engine
// Sizes of the list, operation and status codes, sequencer states and the
// structures that pass between the sequencer, the entry store and the top.
// ----------------------------------------------------------------------------
package plen_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int OP_W     = 2;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_READOUT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_BAD_POS = 2'd1,
		STS_FULL    = 2'd2,
		STS_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_DEL_RD0,
		ST_DEL_CAP,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_RO_RD,
		ST_RO_OUT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [DATA_W-1:0] wr_data;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic [CNT_W-1:0]  idx;
		status_t           status;
		logic [CNT_W-1:0]  cnt;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

// File: sv/plen_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plen_store: entry storage of the positional list engine
// One write port and one read port with registered read data. The read
// data holds its value until the next read.
// ----------------------------------------------------------------------------
module plen_store
	import plen_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          mem,
	output logic [DATA_W-1:0]      rd_data
);

	logic [DATA_W-1:0] entries_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			entries_q[mem.wr_addr] <= mem.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem.rd_en) begin
			rd_data <= entries_q[mem.rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: sv/plen_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plen_ctrl: sequencer of the positional list engine
// Decodes a request, walks the entry store one cell at a time with a single
// shared pointer step and compare, and presents the results in order.
// ----------------------------------------------------------------------------
module plen_ctrl
	import plen_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic              res_ready,
	output logic                   res_valid,
	output res_t                   res,
	output mem_req_t               mem,
	input  wire logic [DATA_W-1:0] rd_data
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  tgt_q;
	logic [DATA_W-1:0] ins_val_q;
	logic [DATA_W-1:0] emv_q;
	logic [CNT_W-1:0]  emi_q;
	status_t           ems_q;

	// Request decode.
	logic              ins_ok, del_ok, full;
	logic [CNT_W-1:0]  pos_c, pos_m1;
	status_t           acc_status;

	assign pos_c  = CNT_W'(position);
	assign pos_m1 = pos_c - 1'b1;
	assign full   = (count_q == CAP_CNT);
	assign ins_ok = (position != '0) &&
		({1'b0, position} <= ((POS_W + 1)'(count_q) + 1'b1));
	assign del_ok = (position != '0) && ({1'b0, position} <= (POS_W + 1)'(count_q));

	always_comb begin
		case (op_t'(op))
			OP_INSERT:  acc_status = !ins_ok ? STS_BAD_POS : (full ? STS_FULL : STS_OK);
			OP_DELETE:  acc_status = del_ok ? STS_OK : STS_BAD_POS;
			OP_READOUT: acc_status = (count_q == '0) ? STS_EMPTY : STS_OK;
			default:    acc_status = STS_OK;
		endcase
	end

	// Shared pointer unit: one step (down while shifting for an insert, up
	// otherwise) and one equality compare against the stop point.
	logic             step_dn;
	logic [CNT_W-1:0] adj, stop_ref;
	logic             hit;

	assign step_dn  = (state_q == ST_INS_RD) || (state_q == ST_INS_WR);
	assign adj      = step_dn ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
	assign stop_ref = step_dn ? tgt_q : count_q;
	assign hit      = (adj == stop_ref);

	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem       = '0;
		res_valid = 1'b0;
		res       = '{val: '0, idx: '0, status: STS_OK, cnt: count_q, last: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (op_t'(op))
						OP_INSERT: begin
							if (!ins_ok || full) begin
								state_d = ST_EMIT;
							end else if (pos_m1 == count_q) begin
								state_d = ST_INS_PUT;
							end else begin
								state_d = ST_INS_RD;
							end
						end
						OP_DELETE: begin
							state_d = del_ok ? ST_DEL_RD0 : ST_EMIT;
						end
						OP_READOUT: begin
							state_d = (count_q == '0) ? ST_EMIT : ST_RO_RD;
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_INS_RD: begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = adj[IDX_W-1:0];
				state_d     = ST_INS_WR;
			end
			ST_INS_WR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = ptr_q[IDX_W-1:0];
				mem.wr_data = rd_data;
				state_d     = hit ? ST_INS_PUT : ST_INS_RD;
			end
			ST_INS_PUT: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = tgt_q[IDX_W-1:0];
				mem.wr_data = ins_val_q;
				state_d     = ST_EMIT;
			end
			ST_DEL_RD0: begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = tgt_q[IDX_W-1:0];
				state_d     = ST_DEL_CAP;
			end
			ST_DEL_CAP: begin
				state_d = ST_DEL_RD;
			end
			ST_DEL_RD: begin
				if (hit) begin
					state_d = ST_EMIT;
				end else begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = adj[IDX_W-1:0];
					state_d     = ST_DEL_WR;
				end
			end
			ST_DEL_WR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = ptr_q[IDX_W-1:0];
				mem.wr_data = rd_data;
				state_d     = ST_DEL_RD;
			end
			ST_RO_RD: begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = ptr_q[IDX_W-1:0];
				state_d     = ST_RO_OUT;
			end
			ST_RO_OUT: begin
				res_valid = 1'b1;
				res.val   = rd_data;
				res.idx   = adj;
				res.last  = hit;
				if (res_ready) begin
					state_d = hit ? ST_IDLE : ST_RO_RD;
				end
			end
			ST_EMIT: begin
				res_valid  = 1'b1;
				res.val    = emv_q;
				res.idx    = emi_q;
				res.status = ems_q;
				res.last   = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_INS_PUT) begin
			count_q <= count_q + 1'b1;
		end else if ((state_q == ST_DEL_RD) && hit) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ins_val_q <= value;
					tgt_q     <= pos_m1;
					ptr_q     <= (op_t'(op) == OP_READOUT) ? '0 : count_q;
					emv_q     <= '0;
					emi_q     <= ((op_t'(op) == OP_DELETE) && del_ok) ? pos_c : '0;
					ems_q     <= acc_status;
				end
			end
			ST_INS_WR, ST_DEL_WR: begin
				ptr_q <= adj;
			end
			ST_DEL_CAP: begin
				emv_q <= rd_data;
				ptr_q <= tgt_q;
			end
			ST_RO_OUT: begin
				if (res_ready && !hit) begin
					ptr_q <= adj;
				end
			end
			default: begin
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	a_count_steps_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q))))
		else $error("entry count moved by more than one");

	a_readout_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RO_OUT) |-> ((adj != '0) && (adj <= count_q)))
		else $error("read-out index outside the list");

	a_emit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && res_ready) |=> (state_q == ST_IDLE))
		else $error("single result delivered but sequencer not idle");

endmodule
`default_nettype wire

// File: sv/positional_list_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list of signed values by position
// Holds up to CAPACITY entries and serves insert, delete and read-out
// requests, one request at a time.
// ----------------------------------------------------------------------------
// Usage. A request (op, value, position) is taken on req_valid with req_stall
// low; req_stall stays high from the cycle after acceptance until the last
// result of that request has been handed to the output register. Results
// leave on rsp_valid/rsp_stall and carry item_value, item_index, status,
// entry_count and last; last marks the final result of a request.
// Sequence. Each request walks the entry store one cell at a time: insert
// moves each entry from the end down to the position one cell up, a read
// then a write, then writes the new value; delete reads the removed entry,
// then moves each later entry one cell down; read-out reads and presents each
// entry in turn; a failed or empty request goes straight to its result.
// Reset. arst_n clears the entry count, the sequencer and the output valid;
// entry contents are not cleared, since cells beyond the count are never
// read.
// Back-pressure. While rsp_stall is high the output register holds its
// result, and the sequencer waits with its next result until the register
// frees.
// ----------------------------------------------------------------------------
module positional_list_engine_core
	import plen_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic [OP_W-1:0]          op,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [POS_W-1:0]         position,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic signed [DATA_W-1:0]      item_value,
	output logic [CNT_W-1:0]              item_index,
	output logic [1:0]                    status,
	output logic [CNT_W-1:0]              entry_count,
	output logic                          last
);

	logic              res_valid;
	logic              res_ready;
	res_t              res;
	mem_req_t          mem;
	logic [DATA_W-1:0] rd_data;

	// Output register state.
	logic rsp_valid_q;
	res_t rsp_q;

	plen_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.value     (value),
		.position  (position),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.mem       (mem),
		.rd_data   (rd_data)
	);

	plen_store u_store (
		.clk     (clk),
		.mem     (mem),
		.rd_data (rd_data)
	);

	// The register may take a new result when it is empty or when its
	// current result is being taken in this very cycle.
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign item_value  = rsp_q.val;
	assign item_index  = rsp_q.idx;
	assign status      = rsp_q.status;
	assign entry_count = rsp_q.cnt;
	assign last        = rsp_q.last;

endmodule
`default_nettype wire

// File: tb/sv/positional_list_engine_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb: self-checking bench for the list engine
// A short table of directed requests covers the empty list, bad positions,
// the full list, the unused selector and value extremes. Several hundred
// random requests follow, mostly well formed. Every result is compared
// field by field with an in-bench prediction, under three idling patterns.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb
	import plen_pkg::*;
();

	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 350;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		op_t               op_code;
		logic [DATA_W-1:0] val;
		logic [POS_W-1:0]  pos;
		bit                typed;
		status_t           want_status;
		logic [CNT_W-1:0]  want_cnt;
	} request_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [OP_W-1:0]          op = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic signed [DATA_W-1:0] item_value;
	logic [CNT_W-1:0]         item_index;
	logic [1:0]               status;
	logic [CNT_W-1:0]         entry_count;
	logic                     last;

	// Predicted list contents and the results still owed by the block.
	logic [DATA_W-1:0] list_cells [CAPACITY];
	int                list_count = 0;
	res_t              step_out [$];
	res_t              pending_results [$];
	request_row_t      directed_rows [$];

	int send_idle_pct = 13;
	int recv_idle_pct = 57;
	int fail_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int full_hits = 0;
	int bad_pos_hits = 0;
	int readouts = 0;
	int idle_cycles = 0;

	positional_list_engine_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.value       (value),
		.position    (position),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.item_value  (item_value),
		.item_index  (item_index),
		.status      (status),
		.entry_count (entry_count),
		.last        (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic res_t make_result(logic [DATA_W-1:0] v, int idx, status_t s, bit is_last);
		res_t r;
		r.val    = v;
		r.idx    = CNT_W'(idx);
		r.status = s;
		r.cnt    = CNT_W'(list_count);
		r.last   = is_last;
		return r;
	endfunction

	// Applies one request to the predicted list and leaves its results in step_out.
	task automatic predict_list_op(input op_t o, input logic [DATA_W-1:0] v,
			input logic [POS_W-1:0] p);
		int k;
		logic [DATA_W-1:0] removed;
		step_out.delete();
		case (o)
			OP_INSERT: begin
				if (p < 1 || p > list_count + 1) begin
					bad_pos_hits++;
					step_out.push_back(make_result('0, 0, STS_BAD_POS, 1'b1));
				end else if (list_count >= CAPACITY) begin
					full_hits++;
					step_out.push_back(make_result('0, 0, STS_FULL, 1'b1));
				end else begin
					for (k = list_count; k > p - 1; k--)
						list_cells[k] = list_cells[k-1];
					list_cells[p-1] = v;
					list_count++;
					step_out.push_back(make_result('0, 0, STS_OK, 1'b1));
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > list_count) begin
					bad_pos_hits++;
					step_out.push_back(make_result('0, 0, STS_BAD_POS, 1'b1));
				end else begin
					removed = list_cells[p-1];
					for (k = p - 1; k < list_count - 1; k++)
						list_cells[k] = list_cells[k+1];
					list_count--;
					step_out.push_back(make_result(removed, p, STS_OK, 1'b1));
				end
			end
			OP_READOUT: begin
				readouts++;
				if (list_count == 0)
					step_out.push_back(make_result('0, 0, STS_EMPTY, 1'b1));
				else
					for (k = 0; k < list_count; k++)
						step_out.push_back(make_result(list_cells[k], k + 1, STS_OK,
							k + 1 == list_count));
			end
			default: begin
				step_out.push_back(make_result('0, 0, STS_OK, 1'b1));
			end
		endcase
	endtask

	// Presents one request, holds it until taken, then books its results.
	task automatic send_request(input request_row_t row);
		res_t want;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= row.op_code;
		value     <= row.val;
		position  <= row.pos;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		requests_sent++;
		predict_list_op(row.op_code, row.val, row.pos);
		if (row.typed) begin
			want.val    = '0;
			want.idx    = '0;
			want.status = row.want_status;
			want.cnt    = row.want_cnt;
			want.last   = 1'b1;
			pending_results.push_back(want);
		end else begin
			foreach (step_out[i])
				pending_results.push_back(step_out[i]);
		end
	endtask

	// Drops valid and waits until the block has handed over everything owed.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input op_t o, input logic [DATA_W-1:0] v, input int p,
			input bit typed, input status_t s, input int c);
		request_row_t row;
		row.op_code     = o;
		row.val         = v;
		row.pos         = POS_W'(p);
		row.typed       = typed;
		row.want_status = s;
		row.want_cnt    = CNT_W'(c);
		directed_rows.push_back(row);
	endtask

	// Result side: random stall, and every accepted result checked in order.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				fail_count++;
				$error("result arrived with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (item_value !== want.val) begin
					fail_count++;
					$error("item_value: expected %0d, got %0d", $signed(want.val), item_value);
				end
				if (item_index !== want.idx) begin
					fail_count++;
					$error("item_index: expected %0d, got %0d", want.idx, item_index);
				end
				if (status !== want.status) begin
					fail_count++;
					$error("status: expected %0d, got %0d", want.status, status);
				end
				if (entry_count !== want.cnt) begin
					fail_count++;
					$error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
				end
				if (last !== want.last) begin
					fail_count++;
					$error("last: expected %0d, got %0d", want.last, last);
				end
			end
		end
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		request_row_t row;
		int n;
		int phase;
		int r;
		int pick;
		int c;

		// Directed part: empty list, bad positions, extremes, then fill to capacity.
		add_row(OP_READOUT, '0, 0, 1'b1, STS_EMPTY, 0);
		add_row(OP_DELETE, '0, 1, 1'b1, STS_BAD_POS, 0);
		add_row(OP_INSERT, 32'd5, 0, 1'b1, STS_BAD_POS, 0);
		add_row(OP_INSERT, 32'd6, 2, 1'b1, STS_BAD_POS, 0);
		add_row(OP_NONE, 32'hFFFF_FFFF, 255, 1'b1, STS_OK, 0);
		add_row(OP_INSERT, 32'h7FFF_FFFF, 1, 1'b1, STS_OK, 1);
		add_row(OP_INSERT, 32'h8000_0000, 1, 1'b1, STS_OK, 2);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 3, 1'b1, STS_OK, 3);
		add_row(OP_INSERT, 32'h0000_0000, 2, 1'b1, STS_OK, 4);
		add_row(OP_READOUT, '0, 0, 1'b0, STS_OK, 0);
		add_row(OP_DELETE, '0, 0, 1'b1, STS_BAD_POS, 4);
		add_row(OP_DELETE, '0, 5, 1'b1, STS_BAD_POS, 4);
		for (n = 0; n < CAPACITY - 4; n++) begin
			c = 4 + n;
			pick = (n % 3 == 0) ? 1 : (n % 3 == 1) ? c + 1 : c / 2 + 1;
			add_row(OP_INSERT, $urandom, pick, 1'b0, STS_OK, 0);
		end
		// A valid position into a full list reports full; a bad one still wins.
		add_row(OP_INSERT, 32'h1234_5678, CAPACITY + 1, 1'b1, STS_FULL, CAPACITY);
		add_row(OP_INSERT, 32'h1234_5678, 255, 1'b1, STS_BAD_POS, CAPACITY);
		add_row(OP_READOUT, '0, 0, 1'b0, STS_OK, 0);
		add_row(OP_DELETE, '0, CAPACITY, 1'b0, STS_OK, 0);
		add_row(OP_DELETE, '0, 1, 1'b0, STS_OK, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i]);
		wait_for_results();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 13; recv_idle_pct = 57; end
				1: begin send_idle_pct = 57; recv_idle_pct = 13; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
				r = $urandom_range(99);
				pick = $urandom_range(9);
				row.typed = 1'b0;
				row.want_status = STS_OK;
				row.want_cnt = '0;
				case (pick)
					0: row.val = 32'h7FFF_FFFF;
					1: row.val = 32'h8000_0000;
					2: row.val = 32'h0000_0000;
					3: row.val = 32'hFFFF_FFFF;
					default: row.val = $urandom;
				endcase
				if (r < 8) begin
					// Noise: any selector and any position.
					row.op_code = op_t'($urandom_range(3));
					row.pos     = POS_W'($urandom_range(255));
				end else if (r < 58) begin
					row.op_code = OP_INSERT;
					row.pos = (pick == 0) ? POS_W'(1) : (pick == 1) ? POS_W'(list_count + 1)
						: POS_W'($urandom_range(list_count + 1, 1));
				end else if (r < 88) begin
					row.op_code = OP_DELETE;
					row.pos = (list_count == 0) ? POS_W'(1)
						: (pick == 0) ? POS_W'(list_count)
						: POS_W'($urandom_range(list_count, 1));
				end else if (r < 98) begin
					row.op_code = OP_READOUT;
					row.pos     = POS_W'($urandom_range(255));
				end else begin
					row.op_code = OP_NONE;
					row.pos     = POS_W'($urandom_range(255));
				end
				send_request(row);
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests and %0d results: %0d read-outs, %0d full-list",
			requests_sent, results_checked, readouts, full_hits);
		$display("and %0d bad-position cases, under three idling patterns.", bad_pos_hits);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
